// ===== hw/rtl/wsfe_pkg.sv =====
// shared types and constants of the weather sensor frame encoder
// frame word layout, digest key table; no dependencies
package wsfe_pkg;

  localparam int PAY_BYTES = 15;
  localparam int DIG_BITS  = 8 * PAY_BYTES;
  localparam int FRAME_LEN = 24;

  localparam logic [7:0]  PREAMBLE   = 8'hAA;
  localparam logic [7:0]  SYNC_HI    = 8'h2D;
  localparam logic [7:0]  SYNC_LO    = 8'hD4;
  localparam logic [15:0] DIG_POLY   = 16'h8810;
  localparam logic [15:0] DIG_KEY    = 16'h5412;
  localparam logic [3:0]  CODE_RESET = 4'd1;

  localparam logic [4:0] IDX_SYNC_HI = 5'd4;
  localparam logic [4:0] IDX_SYNC_LO = 5'd5;
  localparam logic [4:0] IDX_DIG_HI  = 5'd6;
  localparam logic [4:0] IDX_DIG_LO  = 5'd7;
  localparam logic [4:0] IDX_PAY     = 5'd8;
  localparam logic [4:0] IDX_LAST    = 5'd23;

  typedef logic [DIG_BITS-1:0][15:0] key_tab_t;

  typedef struct packed {
    logic [PAY_BYTES-1:0][7:0] pay;
    logic [15:0]               digest;
    logic [7:0]                chk;
  } frame_t;

  typedef struct packed {
    logic   push;
    frame_t entry;
  } q_wr_t;

  function automatic key_tab_t build_key_tab();
    key_tab_t    tab;
    logic [15:0] key;
    key = DIG_KEY;
    for (int n = 0; n < DIG_BITS; n++) begin
      tab[n] = key;
      key = key[0] ? ((key >> 1) ^ DIG_POLY) : (key >> 1);
    end
    return tab;
  endfunction

  localparam key_tab_t KEY_TAB = build_key_tab();

endpackage

// ===== hw/rtl/wsfe_front.sv =====
// front part: takes a reading, clamps and classifies it, converts to bcd
// and builds the payload with digest and checksum; uses wsfe_pkg
module wsfe_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [3:0]           cfg_wr_data,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [31:0]          in_sensor_ident,
  input  logic [3:0]           in_sensor_kind,
  input  logic                 in_starting_up,
  input  logic [2:0]           in_channel_number,
  input  logic [9:0]           in_gust_tenths,
  input  logic [9:0]           in_average_wind_tenths,
  input  logic [8:0]           in_direction_degrees,
  input  logic signed [10:0]   in_temperature_tenths,
  input  logic [6:0]           in_humidity_percent,
  input  logic [19:0]          in_rain_tenths,
  input  logic [9:0]           in_ultraviolet_tenths,
  input  logic                 in_battery_good,
  input  logic                 q_full,
  output wsfe_pkg::q_wr_t      q_wr
);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_CONV = 5'b00010,
    F_ASM  = 5'b00100,
    F_DIG  = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_t;

  typedef enum logic [1:0] {
    FORM_NONE,
    FORM_TEMP,
    FORM_RAIN
  } form_t;

  typedef struct packed {
    logic [31:0] id;
    logic [7:0]  byte6;
    form_t       form;
    logic        neg;
    logic        batt;
  } hdr_t;

  typedef struct packed {
    hdr_t        hdr;
    logic [9:0]  gust;
    logic [9:0]  avg;
    logic [8:0]  dir;
    logic [9:0]  tval;
    logic [6:0]  hum;
    logic [19:0] rain;
    logic [9:0]  uv;
  } slot_t;

  localparam int LANES  = 7;
  localparam int L_GUST = 0;
  localparam int L_AVG  = 1;
  localparam int L_DIR  = 2;
  localparam int L_TEMP = 3;
  localparam int L_HUM  = 4;
  localparam int L_RAIN = 5;
  localparam int L_UV   = 6;
  localparam logic [3:0] CONV_LAST = 4'd9;

  function automatic logic [43:0] dd_step(input logic [43:0] v);
    logic [23:0] bcd;
    bcd = v[43:20];
    for (int d = 0; d < 6; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        bcd[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end
    end
    return {bcd[22:0], v[19:0], 1'b0};
  endfunction

  fstate_t state_r, state_nxt;
  logic [3:0] cfg_code_r;
  logic rain_next_r;
  logic slot_v_r, slot_v_nxt;
  slot_t slot_r, slot_in;
  hdr_t cur_r;
  logic [43:0] lane_r [LANES];
  logic [3:0] conv_cnt_r;
  logic [wsfe_pkg::PAY_BYTES-1:0][7:0] pay_r, pay_nxt;
  logic [15:0] part_r [wsfe_pkg::PAY_BYTES];
  logic [15:0] part_nxt [wsfe_pkg::PAY_BYTES];
  logic [10:0] sum_r [3];
  logic [10:0] sum_nxt [3];
  logic acc, load, match;
  logic signed [10:0] t_clamp, t_plus;
  logic [15:0] digest;
  logic [12:0] total;
  logic [3:0] flags;

  assign acc     = in_push & ~in_full;
  assign load    = slot_v_r & (state_r == F_IDLE);
  assign in_full = slot_v_r & ~load;
  assign match   = (in_sensor_kind == cfg_code_r);

  always_comb begin
    if (in_temperature_tenths > 11'sd999) begin
      t_clamp = 11'sd999;
    end else if (in_temperature_tenths < -11'sd999) begin
      t_clamp = -11'sd999;
    end else begin
      t_clamp = in_temperature_tenths;
    end
    t_plus = t_clamp + 11'sd1000;

    slot_in.hdr.id    = in_sensor_ident;
    slot_in.hdr.byte6 = {in_sensor_kind, ~in_starting_up, in_channel_number};
    if (!match) begin
      slot_in.hdr.form = FORM_NONE;
    end else if (rain_next_r) begin
      slot_in.hdr.form = FORM_RAIN;
    end else begin
      slot_in.hdr.form = FORM_TEMP;
    end
    slot_in.hdr.neg  = t_clamp[10];
    slot_in.hdr.batt = in_battery_good;
    slot_in.gust = (in_gust_tenths > 10'd999) ? 10'd999 : in_gust_tenths;
    slot_in.avg  = (in_average_wind_tenths > 10'd999) ? 10'd999 : in_average_wind_tenths;
    slot_in.dir  = (in_direction_degrees > 9'd359) ? 9'd359 : in_direction_degrees;
    slot_in.tval = t_clamp[10] ? t_plus[9:0] : t_clamp[9:0];
    slot_in.hum  = (in_humidity_percent > 7'd99) ? 7'd99 : in_humidity_percent;
    slot_in.rain = (in_rain_tenths > 20'd999999) ? 20'd999999 : in_rain_tenths;
    slot_in.uv   = (in_ultraviolet_tenths > 10'd999) ? 10'd999 : in_ultraviolet_tenths;
  end

  always_comb begin
    slot_v_nxt = slot_v_r;
    if (acc) begin
      slot_v_nxt = 1'b1;
    end else if (load) begin
      slot_v_nxt = 1'b0;
    end
  end

  // payload bytes 0..4 from the header, 5..14 from the bcd lanes
  always_comb begin
    pay_nxt[0] = cur_r.id[31:24];
    pay_nxt[1] = cur_r.id[23:16];
    pay_nxt[2] = cur_r.id[15:8];
    pay_nxt[3] = cur_r.id[7:0];
    pay_nxt[4] = cur_r.byte6;
    pay_nxt[5] = ~{lane_r[L_GUST][31:28], lane_r[L_GUST][27:24]};
    pay_nxt[6] = ~{lane_r[L_GUST][23:20], lane_r[L_AVG][23:20]};
    pay_nxt[7] = ~{lane_r[L_AVG][31:28], lane_r[L_AVG][27:24]};
    pay_nxt[8] = {lane_r[L_DIR][31:28], lane_r[L_DIR][27:24]};
    pay_nxt[9] = {lane_r[L_DIR][23:20], 4'h0};
    flags = 4'h0;
    case (cur_r.form)
      FORM_TEMP: begin
        pay_nxt[10] = {lane_r[L_TEMP][31:28], lane_r[L_TEMP][27:24]};
        pay_nxt[11] = {lane_r[L_TEMP][23:20], cur_r.neg, 1'b0, cur_r.batt, 1'b0};
        pay_nxt[12] = {lane_r[L_HUM][27:24], lane_r[L_HUM][23:20]};
      end
      FORM_RAIN: begin
        pay_nxt[10] = ~lane_r[L_RAIN][43:36];
        pay_nxt[11] = ~lane_r[L_RAIN][35:28];
        pay_nxt[12] = ~lane_r[L_RAIN][27:20];
        flags = 4'h1;
      end
      default: begin
        pay_nxt[10] = 8'h00;
        pay_nxt[11] = 8'h00;
        pay_nxt[12] = 8'h00;
      end
    endcase
    pay_nxt[13] = ~{lane_r[L_UV][31:28], lane_r[L_UV][27:24]};
    pay_nxt[14] = {~lane_r[L_UV][23:20], flags};
  end

  // digest partials, one per payload byte, and byte sums in three groups
  always_comb begin
    for (int k = 0; k < wsfe_pkg::PAY_BYTES; k++) begin
      part_nxt[k] = 16'h0000;
      for (int j = 0; j < 8; j++) begin
        if (pay_r[k][7-j]) begin
          part_nxt[k] = part_nxt[k] ^ wsfe_pkg::KEY_TAB[8*k+j];
        end
      end
    end
    for (int g = 0; g < 3; g++) begin
      sum_nxt[g] = 11'd0;
      for (int m = 0; m < 5; m++) begin
        sum_nxt[g] = sum_nxt[g] + {3'd0, pay_r[5*g+m]};
      end
    end
  end

  always_comb begin
    digest = 16'h0000;
    for (int k = 0; k < wsfe_pkg::PAY_BYTES; k++) begin
      digest = digest ^ part_r[k];
    end
    total = {2'd0, sum_r[0]} + {2'd0, sum_r[1]} + {2'd0, sum_r[2]};
  end

  assign q_wr.push         = (state_r == F_PUSH) & ~q_full;
  assign q_wr.entry.pay    = pay_r;
  assign q_wr.entry.digest = digest;
  assign q_wr.entry.chk    = ~total[7:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (slot_v_r) state_nxt = F_CONV;
      end
      F_CONV: begin
        if (conv_cnt_r == CONV_LAST) state_nxt = F_ASM;
      end
      F_ASM:  state_nxt = F_DIG;
      F_DIG:  state_nxt = F_PUSH;
      F_PUSH: begin
        if (!q_full) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_IDLE;
      cfg_code_r  <= wsfe_pkg::CODE_RESET;
      rain_next_r <= 1'b0;
      slot_v_r    <= 1'b0;
      conv_cnt_r  <= 4'd0;
    end else begin
      state_r  <= state_nxt;
      slot_v_r <= slot_v_nxt;
      if (cfg_wr_en) cfg_code_r <= cfg_wr_data;
      if (acc && match) rain_next_r <= ~rain_next_r;
      if (load) begin
        conv_cnt_r <= 4'd0;
      end else if (state_r == F_CONV) begin
        conv_cnt_r <= conv_cnt_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) slot_r <= slot_in;
    if (load) begin
      cur_r <= slot_r.hdr;
      lane_r[L_GUST] <= {24'd0, 10'd0, slot_r.gust};
      lane_r[L_AVG]  <= {24'd0, 10'd0, slot_r.avg};
      lane_r[L_DIR]  <= {24'd0, 11'd0, slot_r.dir};
      lane_r[L_TEMP] <= {24'd0, 10'd0, slot_r.tval};
      lane_r[L_HUM]  <= {24'd0, 13'd0, slot_r.hum};
      lane_r[L_RAIN] <= {24'd0, slot_r.rain};
      lane_r[L_UV]   <= {24'd0, 10'd0, slot_r.uv};
    end else if (state_r == F_CONV) begin
      for (int l = 0; l < LANES; l++) begin
        lane_r[l] <= dd_step(dd_step(lane_r[l]));
      end
    end
    if (state_r == F_ASM) pay_r <= pay_nxt;
    if (state_r == F_DIG) begin
      part_r <= part_nxt;
      sum_r  <= sum_nxt;
    end
  end

endmodule

// ===== hw/rtl/wsfe_queue.sv =====
// short frame queue between front and back
// register array with read and write pointers; uses wsfe_pkg
module wsfe_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  wsfe_pkg::q_wr_t  q_wr,
  output logic             q_full,
  input  logic             q_pop,
  output logic             q_empty,
  output wsfe_pkg::frame_t q_head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  wsfe_pkg::frame_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign q_full  = (cnt_r == CW'(DEPTH));
  assign q_empty = (cnt_r == '0);
  assign q_head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (q_wr.push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (q_pop) rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (q_wr.push && !q_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (!q_wr.push && q_pop) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) mem_r[wr_ptr_r] <= q_wr.entry;
  end

endmodule

// ===== hw/rtl/wsfe_back.sv =====
// back part: sends a queued frame as 24 words, preamble and sync first
// frame register with byte index; uses wsfe_pkg
module wsfe_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  wsfe_pkg::frame_t q_head,
  output logic             q_pop,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [7:0]       out_frame_byte,
  output logic             out_last_byte
);

  wsfe_pkg::frame_t frame_r;
  logic frame_v_r;
  logic [4:0] idx_r;
  logic [4:0] pay_off;
  logic take, last;

  assign last    = (idx_r == wsfe_pkg::IDX_LAST);
  assign take    = out_pop & frame_v_r;
  assign q_pop   = ~q_empty & (~frame_v_r | (take & last));
  assign pay_off = idx_r - wsfe_pkg::IDX_PAY;

  assign out_empty     = ~frame_v_r;
  assign out_last_byte = last;

  always_comb begin
    unique case (idx_r) inside
      [5'd0:5'd3]:              out_frame_byte = wsfe_pkg::PREAMBLE;
      wsfe_pkg::IDX_SYNC_HI:    out_frame_byte = wsfe_pkg::SYNC_HI;
      wsfe_pkg::IDX_SYNC_LO:    out_frame_byte = wsfe_pkg::SYNC_LO;
      wsfe_pkg::IDX_DIG_HI:     out_frame_byte = frame_r.digest[15:8];
      wsfe_pkg::IDX_DIG_LO:     out_frame_byte = frame_r.digest[7:0];
      [5'd8:5'd22]:             out_frame_byte = frame_r.pay[pay_off[3:0]];
      wsfe_pkg::IDX_LAST:       out_frame_byte = frame_r.chk;
      default:                  out_frame_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_v_r <= 1'b0;
      idx_r     <= 5'd0;
    end else begin
      if (q_pop) begin
        frame_v_r <= 1'b1;
        idx_r     <= 5'd0;
      end else if (take) begin
        if (last) begin
          frame_v_r <= 1'b0;
          idx_r     <= 5'd0;
        end else begin
          idx_r <= idx_r + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) frame_r <= q_head;
  end

endmodule

// ===== hw/rtl/weather_sensor_frame_encoder_unit.sv =====
// top level of the weather sensor frame encoder
// connects wsfe_front, wsfe_queue and wsfe_back; uses wsfe_pkg
//
// One reading in, one 24-word radio frame out (preamble, sync, digest,
// payload, checksum), one frame byte per pop. A reading is taken into an
// input register while the previous one is still converted; per reading
// the front does a load, the bcd conversion with two bcd steps per
// conversion cycle, payload assembly, a digest step and the queue write.
// The back sends one byte per cycle while out_pop is held and starts the
// next queued frame right after the last byte, so the byte serializer sets
// the sustained rate. Up to QUEUE_DEPTH frames wait between front and back.
module weather_sensor_frame_encoder_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [3:0]         cfg_wr_data,
  input  logic               in_push,
  output logic               in_full,
  input  logic [31:0]        in_sensor_ident,
  input  logic [3:0]         in_sensor_kind,
  input  logic               in_starting_up,
  input  logic [2:0]         in_channel_number,
  input  logic [9:0]         in_gust_tenths,
  input  logic [9:0]         in_average_wind_tenths,
  input  logic [8:0]         in_direction_degrees,
  input  logic signed [10:0] in_temperature_tenths,
  input  logic [6:0]         in_humidity_percent,
  input  logic [19:0]        in_rain_tenths,
  input  logic [9:0]         in_ultraviolet_tenths,
  input  logic               in_battery_good,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [7:0]         out_frame_byte,
  output logic               out_last_byte
);

  wsfe_pkg::q_wr_t  q_wr;
  wsfe_pkg::frame_t q_head;
  logic q_full, q_empty, q_pop;

  wsfe_front u_front (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_wr_data            (cfg_wr_data),
    .in_push                (in_push),
    .in_full                (in_full),
    .in_sensor_ident        (in_sensor_ident),
    .in_sensor_kind         (in_sensor_kind),
    .in_starting_up         (in_starting_up),
    .in_channel_number      (in_channel_number),
    .in_gust_tenths         (in_gust_tenths),
    .in_average_wind_tenths (in_average_wind_tenths),
    .in_direction_degrees   (in_direction_degrees),
    .in_temperature_tenths  (in_temperature_tenths),
    .in_humidity_percent    (in_humidity_percent),
    .in_rain_tenths         (in_rain_tenths),
    .in_ultraviolet_tenths  (in_ultraviolet_tenths),
    .in_battery_good        (in_battery_good),
    .q_full                 (q_full),
    .q_wr                   (q_wr)
  );

  wsfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_wr    (q_wr),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_head  (q_head)
  );

  wsfe_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte)
  );

endmodule

// ===== hw/rtl/wsfe_checker.sv =====
// port-level checks of the weather sensor frame encoder
// bound to weather_sensor_frame_encoder_unit; no package use
module wsfe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic [7:0] out_frame_byte,
  input logic       out_last_byte
);

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not cleared by reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_frame_byte) && $stable(out_last_byte)))
    else $error("waiting word changed");

  a_frame_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && !out_last_byte) |=> !out_empty)
    else $error("frame broken off before its last word");

  a_next_frame_preamble: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && out_last_byte) |=>
      (out_empty || (out_frame_byte == 8'hAA && !out_last_byte)))
    else $error("frame after last word does not start with preamble");

  a_start_preamble: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_empty) |-> (out_frame_byte == 8'hAA && !out_last_byte))
    else $error("frame does not start with preamble");

endmodule

bind weather_sensor_frame_encoder_unit wsfe_checker u_wsfe_checker (.*);
